FILE: hw/rtl/fpdt_pkg.sv
// ----------------------------------------------------------------------------
// fpdt_pkg
// Shared types, constants and the FNV-1a byte step for the prefix dedup table.
// ----------------------------------------------------------------------------
`default_nettype none

package fpdt_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [63:0] FNV_BASIS    = 64'd14695981039346656037;
    localparam logic [15:0] PREFIX_RESET = 16'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // take one input word
        logic start;    // last byte taken, open a table scan
        logic issue;    // read the next stored entry
        logic finish;   // load result, append on a miss when there is room
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_last;
        logic issue_more;
        logic cmp_valid;
        logic match;
        logic out_busy;
    } status_t;

    // One FNV-1a step: xor the byte in, multiply by 2^40 + 2^8 + 0xB3.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fpdt_ctrl.sv
// ----------------------------------------------------------------------------
// fpdt_ctrl
// Sequencer: byte intake, table scan, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdt_ctrl
    import fpdt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.in_last)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // stop on a hit, else walk until the read pipe is empty
                if (status.match)
                begin
                    state_next = ST_RESULT;
                end
                else if (status.issue_more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!status.cmp_valid)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fpdt_datapath.sv
// ----------------------------------------------------------------------------
// fpdt_datapath
// Running hash, hash table memory, scan compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdt_datapath
    import fpdt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [15:0]      cfg_wr_data,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    input  wire cmd_t             cmd,
    output status_t               status,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  already_seen,
    output logic                  added,
    output logic [63:0]           hash_value,
    output logic [CNT_W-1:0]      stored_count
);

    logic [15:0]       prefix_limit_reg;
    logic [63:0]       hash_reg;
    logic [63:0]       hash_next;
    logic [15:0]       bytes_taken_reg;
    logic [15:0]       bytes_taken_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              cmp_valid_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    logic [63:0]       key_reg;
    logic [63:0]       rdata_reg;
    logic              seen_reg;
    logic              added_reg;
    logic [63:0]       hash_out_reg;
    logic [CNT_W-1:0]  count_out_reg;

    logic [63:0]       mem [TABLE_DEPTH];

    logic              take_byte;
    logic              has_room;
    logic              do_append;

    assign take_byte = bytes_taken_reg < prefix_limit_reg;
    assign has_room  = count_reg < CNT_W'(TABLE_DEPTH);
    assign do_append = cmd.finish && !hit_reg && has_room;
    assign hash_next = take_byte ? fnv_step(hash_reg, data_byte) : hash_reg;
    assign bytes_taken_next = take_byte ? bytes_taken_reg + 16'd1 : bytes_taken_reg;
    assign count_next = CNT_W'(count_reg + 1'b1);

    always_comb
    begin
        status.in_last    = last_byte;
        status.issue_more = scan_idx_reg < count_reg;
        status.cmp_valid  = cmp_valid_reg;
        status.match      = cmp_valid_reg && (rdata_reg == key_reg);
        status.out_busy   = out_valid_reg && !out_ready;
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_limit_reg <= PREFIX_RESET;
            hash_reg         <= FNV_BASIS;
            bytes_taken_reg  <= '0;
            count_reg        <= '0;
            scan_idx_reg     <= '0;
            cmp_valid_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prefix_limit_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                if (last_byte)
                begin
                    hash_reg        <= FNV_BASIS;
                    bytes_taken_reg <= '0;
                end
                else
                begin
                    hash_reg        <= hash_next;
                    bytes_taken_reg <= bytes_taken_next;
                end
            end
            if (cmd.start)
            begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_idx_reg <= CNT_W'(scan_idx_reg + 1'b1);
                end
                if (status.match)
                begin
                    hit_reg <= 1'b1;
                end
            end
            cmp_valid_reg <= cmd.issue;
            if (do_append)
            begin
                count_reg <= count_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= hash_next;
        end
        if (cmd.finish)
        begin
            seen_reg      <= hit_reg;
            added_reg     <= !hit_reg && has_room;
            hash_out_reg  <= key_reg;
            count_out_reg <= do_append ? count_next : count_reg;
        end
    end

    // hash table: one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rdata_reg <= mem[scan_idx_reg[ADDR_W-1:0]];
        end
        if (do_append)
        begin
            mem[count_reg[ADDR_W-1:0]] <= key_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign already_seen = seen_reg;
    assign added        = added_reg;
    assign hash_value   = hash_out_reg;
    assign stored_count = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("append did not advance entry count");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg && (stored_count == $past(count_next)
            || stored_count == $past(count_reg)))
        else $error("result not presented after finish");

    a_seen_added: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(seen_reg && added_reg))
        else $error("result both seen and added");

endmodule

`default_nettype wire

FILE: hw/rtl/fnv1a_prefix_dedup_table_top.sv
// ----------------------------------------------------------------------------
// fnv1a_prefix_dedup_table_top
// FNV-1a 64-bit prefix hash with a deduplicating table of stored hashes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per data byte, last_byte set
//   on the final byte of a block. Only the first prefix_limit bytes of a block
//   enter the hash; write prefix_limit through cfg_wr_en/cfg_wr_data while
//   the block is idle.
//   Output channel (out_valid/out_ready): one word per block, issued after
//   the last byte, carrying already_seen, added, hash_value, stored_count.
//   Throughput: non-last bytes are taken one per cycle, each hashed by a
//   shift-add constant multiply. After a last byte the block walks the
//   stored entries through the table's one read port, one entry per cycle,
//   until a hit or until all N stored entries are read. Input is held off
//   during the walk.
//   Stall: a finished result sits in the output register; the block goes on
//   taking bytes of the next block, and holds its next result until the
//   output register is free.
//   Reset: hash at the offset basis, byte count and table count at zero,
//   prefix_limit at 1000. Table contents are not cleared; only entries below
//   the stored count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv1a_prefix_dedup_table_top
    import fpdt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [15:0]      cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  already_seen,
    output logic                  added,
    output logic [63:0]           hash_value,
    output logic [CNT_W-1:0]      stored_count
);

    cmd_t    cmd;
    status_t status;

    // sequencer: intake, scan, result
    fpdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hash, table and output register
    fpdt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .already_seen (already_seen),
        .added        (added),
        .hash_value   (hash_value),
        .stored_count (stored_count)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FNV-1a prefix dedup table. Streams data blocks
// one byte word at a time, tracks the prefix hash and the table of stored
// hashes on the side, and checks each result word field by field against
// what the table must answer. Sweeps the prefix limit across phases, with
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import fpdt_pkg::*;

    localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;
    localparam int          MAX_BLK_LEN = 48;
    localparam int          POOL_SLOTS  = 256;
    localparam int          RAND_WORDS  = 1550;
    localparam int          PHASE_WORDS = 150;
    localparam int          HOLD_CYCLES = 400;
    localparam int          IDLE_PCT    = 8;
    localparam int          QUIET_PHASE = 3;
    localparam int          HOLD_PHASE  = 1;

    // prefix limits of the first random phases; later phases pick at random
    localparam logic [15:0] PHASE_LIMITS [8] = '{16'd1, 16'd65535, 16'd2, 16'd16,
                                                 16'd0, 16'd4, 16'd1000, 16'd8};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_word_t;

    typedef struct packed {
        logic             seen;
        logic             added;
        logic [63:0]      hash;
        logic [CNT_W-1:0] count;
    } verdict_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_wr_en    = 1'b0;
    logic [15:0]      cfg_wr_data  = '0;
    logic             in_valid     = 1'b0;
    logic             in_ready;
    logic [7:0]       data_byte    = '0;
    logic             last_byte    = 1'b0;
    logic             out_valid;
    logic             out_ready    = 1'b0;
    logic             already_seen;
    logic             added;
    logic [63:0]      hash_value;
    logic [CNT_W-1:0] stored_count;

    // pending byte words, expected result words, and the mirrored table
    byte_word_t  byte_q[$];
    verdict_t    verdict_q[$];
    logic [63:0] kept_hashes[$];

    // mirrored hash state and prefix limit
    logic [63:0] acc_hash;
    logic [15:0] acc_taken;
    logic [15:0] prefix_cur;
    logic        in_fire;

    bit quiet      = 1'b0;
    bit hold_armed = 1'b0;
    int hold_done  = 0;
    int err_cnt    = 0;
    int rand_words = 0;

    // blocks already sent, kept for replays that may hit in the table
    logic [7:0] pool_data [POOL_SLOTS][MAX_BLK_LEN];
    int         pool_len  [POOL_SLOTS];
    int         pool_cnt = 0;
    logic [7:0] blk [MAX_BLK_LEN];
    int         blk_len;

    fnv1a_prefix_dedup_table_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .already_seen (already_seen),
        .added        (added),
        .hash_value   (hash_value),
        .stored_count (stored_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] fnv1a_absorb(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Hash and table tracking. Fold each accepted byte word into the running
    // hash while the block is still inside its prefix; on the last byte,
    // search the stored hashes, append on a miss when there is room, and
    // queue the result word the block must return. Then restart the hash.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : track_hash
        logic [63:0] h;
        logic [15:0] n;
        bit          hit;
        verdict_t    v;
        if (!rst_n)
        begin
            acc_hash   <= FNV_BASIS;
            acc_taken  <= '0;
            prefix_cur <= PREFIX_RESET;
            in_fire    <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (cfg_wr_en)
                prefix_cur <= cfg_wr_data;
            if (in_valid && in_ready)
            begin
                h = acc_hash;
                n = acc_taken;
                // count stops at the limit, so bytes past the prefix drop out
                if (n < prefix_cur)
                begin
                    h = fnv1a_absorb(h, data_byte);
                    n = n + 16'd1;
                end
                if (last_byte)
                begin
                    hit = 1'b0;
                    foreach (kept_hashes[i])
                        if (kept_hashes[i] == h)
                            hit = 1'b1;
                    v.seen  = hit;
                    // a new hash on a full table is dropped silently
                    v.added = !hit && kept_hashes.size() < TABLE_DEPTH;
                    if (v.added)
                        kept_hashes.push_back(h);
                    v.hash  = h;
                    v.count = CNT_W'(kept_hashes.size());
                    verdict_q.push_back(v);
                    h = FNV_BASIS;
                    n = '0;
                end
                acc_hash  <= h;
                acc_taken <= n;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every accepted result word must match the oldest
    // expectation in all four fields.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result word with none expected: seen=%0b added=%0b hash=%h count=%0d",
                         $time, already_seen, added, hash_value, stored_count);
                err_cnt++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("already_seen", 64'(want.seen), 64'(already_seen));
                check_field("added", 64'(want.added), 64'(added));
                check_field("hash_value", want.hash, hash_value);
                check_field("stored_count", 64'(want.count), 64'(stored_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte driver. Hold the current word until it is taken, then advance to
    // the next pending word or idle now and then.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_bytes
        byte_word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (byte_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                w = byte_q.pop_front();
                in_valid  <= 1'b1;
                data_byte <= w.data;
                last_byte <= w.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Stall now and then; once armed, hold off for a long
    // stretch so the output register fills and the input backs up.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drain_results
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_armed && hold_done < HOLD_CYCLES)
        begin
            out_ready <= 1'b0;
            hold_done <= hold_done + 1;
        end
        else
            out_ready <= quiet || $urandom_range(99) >= IDLE_PCT;
    end

    task automatic put_word(input logic [7:0] b, input logic l);
        byte_q.push_back('{data: b, last: l});
    endtask

    // Write the prefix limit; the block must be idle here.
    task automatic set_prefix(input logic [15:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Wait until every word is taken and every result is back, then give the
    // table walk time to finish in case the last word ended no block.
    task automatic settle();
        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (kept_hashes.size() + 8) @(posedge clk);
    endtask

    // Build the next random block in blk: an exact replay of an earlier
    // block, a replay with only the bytes past the prefix changed, or a
    // fresh block, mostly short.
    task automatic make_block();
        int r;
        int k;
        int slot;
        r = $urandom_range(99);
        if (pool_cnt != 0 && r < 45)
        begin
            k = $urandom_range(pool_cnt - 1);
            blk_len = pool_len[k];
            for (int i = 0; i < blk_len; i++)
                blk[i] = pool_data[k][i];
            if (r >= 30)
                for (int i = int'(prefix_cur); i < blk_len; i++)
                    blk[i] = 8'($urandom_range(255));
        end
        else
        begin
            blk_len = ($urandom_range(9) == 0) ? $urandom_range(13, MAX_BLK_LEN)
                                               : $urandom_range(1, 8);
            for (int i = 0; i < blk_len; i++)
                blk[i] = 8'($urandom_range(255));
            slot = (pool_cnt < POOL_SLOTS) ? pool_cnt : $urandom_range(POOL_SLOTS - 1);
            if (pool_cnt < POOL_SLOTS)
                pool_cnt++;
            pool_len[slot] = blk_len;
            for (int i = 0; i < blk_len; i++)
                pool_data[slot][i] = blk[i];
        end
    endtask

    // Queue blk as byte words and count every word sent.
    task automatic emit_block();
        for (int i = 0; i < blk_len; i++)
        begin
            put_word(blk[i], i == blk_len - 1);
            rand_words++;
        end
    endtask

    initial
    begin : stimulus
        int          phase;
        int          target;
        logic [15:0] lim;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset limit: extreme byte values, a repeat that must hit, a longer block.
        put_word(8'h00, 1'b1);
        put_word(8'hFF, 1'b1);
        put_word(8'h00, 1'b1);
        put_word(8'hA5, 1'b0);
        put_word(8'h5A, 1'b0);
        put_word(8'h3C, 1'b1);
        settle();

        // Limit of one: the second byte drops out, so the first block hits.
        set_prefix(16'd1);
        put_word(8'h00, 1'b0);
        put_word(8'h77, 1'b1);
        put_word(8'h12, 1'b0);
        put_word(8'h34, 1'b1);
        settle();

        // Limit of zero: every block hashes to the offset basis.
        set_prefix(16'd0);
        put_word(8'h99, 1'b1);
        put_word(8'h11, 1'b0);
        put_word(8'h22, 1'b1);
        settle();

        // Limit lowered in mid-block: bytes already hashed stay in.
        set_prefix(16'd65535);
        put_word(8'hDE, 1'b0);
        put_word(8'hAD, 1'b0);
        settle();
        set_prefix(16'd2);
        put_word(8'hBE, 1'b0);
        put_word(8'hEF, 1'b1);
        settle();

        // Limit raised in mid-block: the new limit takes the next bytes.
        set_prefix(16'd1);
        put_word(8'h01, 1'b0);
        settle();
        set_prefix(16'd3);
        put_word(8'h02, 1'b0);
        put_word(8'h03, 1'b0);
        put_word(8'h04, 1'b1);
        settle();

        // Random phases, one prefix limit each.
        phase = 0;
        while (rand_words < RAND_WORDS)
        begin
            if (phase < 8)
                lim = PHASE_LIMITS[phase];
            else if ($urandom_range(1) == 0)
                lim = 16'($urandom_range(1, 65535));
            else
                lim = 16'($urandom_range(1, 24));
            set_prefix(lim);
            @(posedge clk);
            quiet = (phase == QUIET_PHASE);
            if (phase == HOLD_PHASE)
                hold_armed = 1'b1;
            target = rand_words + PHASE_WORDS;
            while (rand_words < target)
            begin
                make_block();
                emit_block();
            end
            settle();
            phase++;
        end

        if (err_cnt == 0 && verdict_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin : watchdog
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
